// File: rtl/core/itrp_pkg.sv
// Shared types and constants of the indexed text record parser.
package itrp_pkg;

  // Field widths of the result ports
  localparam int unsigned NUM_W      = 16;
  localparam int unsigned LEN_W      = 16;
  localparam int unsigned OFFSET_O_W = 20;
  localparam int unsigned SLOT_W     = 10;

  // Function codes of an input transaction
  localparam logic FUNC_PARSE  = 1'b0;
  localparam logic FUNC_LOOKUP = 1'b1;

  // Result kinds
  localparam logic KIND_PARSE  = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
  localparam logic [1:0] STATUS_DROPPED   = 2'd2;

  // Byte codes recognised by the parser
  localparam logic [7:0] BYTE_STOP  = 8'd26;
  localparam logic [7:0] BYTE_AT    = 8'h40;
  localparam logic [7:0] BYTE_COLON = 8'h3A;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_ZERO  = 8'd48;
  localparam logic [7:0] DEC_BASE   = 8'd10;

  // Saturation limits
  localparam logic [NUM_W-1:0] NUM_MAX = '1;
  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // Parser modes
  typedef enum logic [1:0] {
    PM_SCAN,
    PM_DIGITS,
    PM_TEXT,
    PM_STOP
  } parse_mode_e;

  // Lookup sequencer states
  typedef enum logic {
    LK_IDLE,
    LK_SCAN
  } lookup_state_e;

  // One result transaction
  typedef struct packed {
    logic                  kind;
    logic [1:0]            status;
    logic [NUM_W-1:0]      number;
    logic [OFFSET_O_W-1:0] offset;
    logic [LEN_W-1:0]      length;
    logic [SLOT_W-1:0]     slot;
  } result_t;

endpackage

// File: rtl/core/itrp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module itrp_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/itrp_parser.sv
// Byte parser: record framing, number and length counting, table writes.
module itrp_parser #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned OFFSET_BITS = 20,
  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned ENTRY_W = 2 * itrp_pkg::NUM_W + OFFSET_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  byte_valid_i,
  input  logic [7:0]            data_byte_i,
  output logic [CNT_W-1:0]      count_o,
  output logic                  we_o,
  output logic [IDX_W-1:0]      waddr_o,
  output logic [ENTRY_W-1:0]    wdata_o,
  output logic                  res_valid_o,
  output itrp_pkg::result_t     res_o
);

  import itrp_pkg::*;

  parse_mode_e            mode_q, mode_d;
  logic [NUM_W-1:0]       acc_q, acc_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [CNT_W-1:0]       count_q, count_d;

  logic             is_digit;
  logic             is_text;
  logic             full;
  logic             close;
  logic [7:0]       digit;
  logic [NUM_W+3:0] acc_ext;
  logic [NUM_W-1:0] acc_next;

  // Classify the byte and form the saturated decimal step
  assign is_digit = (data_byte_i >= BYTE_ZERO) && (data_byte_i < (BYTE_ZERO + DEC_BASE));
  assign is_text  = (data_byte_i >= BYTE_SPACE);
  assign digit    = data_byte_i - BYTE_ZERO;
  assign acc_ext  = (NUM_W + 4)'(acc_q) * (NUM_W + 4)'(DEC_BASE) + (NUM_W + 4)'(digit);
  assign acc_next = (acc_ext > (NUM_W + 4)'(NUM_MAX)) ? NUM_MAX : acc_ext[NUM_W-1:0];
  assign full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign close    = byte_valid_i && (mode_q == PM_TEXT) && !is_text;

  // Next mode and datapath state
  always_comb begin
    mode_d  = mode_q;
    acc_d   = acc_q;
    pos_d   = pos_q;
    start_d = start_q;
    len_d   = len_q;
    count_d = count_q;
    if (byte_valid_i) begin
      case (mode_q)
        PM_SCAN: begin
          if (data_byte_i == BYTE_STOP) begin
            mode_d = PM_STOP;
          end else if (data_byte_i == BYTE_AT) begin
            acc_d  = '0;
            mode_d = PM_DIGITS;
          end
        end
        PM_DIGITS: begin
          if (is_digit) begin
            acc_d = acc_next;
          end else if (data_byte_i == BYTE_COLON) begin
            start_d = pos_q + 1'b1;
            len_d   = '0;
            mode_d  = PM_TEXT;
          end else if (data_byte_i == BYTE_STOP) begin
            mode_d = PM_STOP;
          end else begin
            mode_d = PM_SCAN;
          end
        end
        PM_TEXT: begin
          if (is_text) begin
            if (len_q != LEN_MAX) begin
              len_d = len_q + 1'b1;
            end
          end else begin
            if (!full) begin
              count_d = count_q + 1'b1;
            end
            mode_d = PM_SCAN;
          end
        end
        default: begin
          mode_d = mode_q;
        end
      endcase
      // Advance the byte position unless stopped
      if (mode_q != PM_STOP) begin
        pos_d = pos_q + 1'b1;
      end
    end
  end

  // Table write and closed-record result
  always_comb begin
    we_o        = close && !full;
    waddr_o     = count_q[IDX_W-1:0];
    wdata_o     = {acc_q, start_q, len_q};
    res_valid_o = close;
    res_o.kind   = KIND_PARSE;
    res_o.status = full ? STATUS_DROPPED : STATUS_OK;
    res_o.number = acc_q;
    res_o.offset = OFFSET_O_W'(start_q);
    res_o.length = len_q;
    res_o.slot   = full ? '0 : SLOT_W'(count_q);
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= PM_SCAN;
      acc_q   <= '0;
      pos_q   <= '0;
      start_q <= '0;
      len_q   <= '0;
      count_q <= '0;
    end else begin
      mode_q  <= mode_d;
      acc_q   <= acc_d;
      pos_q   <= pos_d;
      start_q <= start_d;
      len_q   <= len_d;
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule

// File: rtl/core/itrp_lookup.sv
// Lookup sequencer: scans stored entries in slot order through the read port.
module itrp_lookup #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned OFFSET_BITS = 20,
  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH),
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1),
  localparam int unsigned ENTRY_W = 2 * itrp_pkg::NUM_W + OFFSET_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [itrp_pkg::NUM_W-1:0] query_i,
  input  logic [CNT_W-1:0]           count_i,
  output logic                       re_o,
  output logic [IDX_W-1:0]           raddr_o,
  input  logic [ENTRY_W-1:0]         rdata_i,
  output logic                       busy_o,
  output logic                       res_valid_o,
  output itrp_pkg::result_t          res_o
);

  import itrp_pkg::*;

  lookup_state_e    state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             rd_valid_q, rd_valid_d;
  logic [IDX_W-1:0] rd_slot_q;
  logic [NUM_W-1:0] query_q;

  logic                   issue;
  logic                   hit;
  logic                   miss_done;
  logic [NUM_W-1:0]       ent_number;
  logic [OFFSET_BITS-1:0] ent_offset;
  logic [LEN_W-1:0]       ent_length;

  // Unpack the entry read last cycle
  assign ent_number = rdata_i[ENTRY_W-1 -: NUM_W];
  assign ent_offset = rdata_i[LEN_W +: OFFSET_BITS];
  assign ent_length = rdata_i[LEN_W-1:0];

  assign issue     = (state_q == LK_SCAN) && (idx_q != count_i);
  assign hit       = (state_q == LK_SCAN) && rd_valid_q && (ent_number == query_q);
  assign miss_done = (state_q == LK_SCAN) && !hit && (idx_q == count_i);

  // Next state
  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    rd_valid_d = 1'b0;
    case (state_q)
      LK_IDLE: begin
        if (start_i) begin
          state_d = LK_SCAN;
          idx_d   = '0;
        end
      end
      LK_SCAN: begin
        if (hit || miss_done) begin
          state_d = LK_IDLE;
        end else begin
          rd_valid_d = issue;
          if (issue) begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = LK_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    re_o        = issue;
    raddr_o     = idx_q[IDX_W-1:0];
    busy_o      = (state_q != LK_IDLE);
    res_valid_o = hit || miss_done;
    res_o.kind  = KIND_LOOKUP;
    if (hit) begin
      res_o.status = STATUS_OK;
      res_o.number = query_q;
      res_o.offset = OFFSET_O_W'(ent_offset);
      res_o.length = ent_length;
      res_o.slot   = SLOT_W'(rd_slot_q);
    end else begin
      res_o.status = STATUS_NOT_FOUND;
      res_o.number = '0;
      res_o.offset = '0;
      res_o.length = '0;
      res_o.slot   = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= LK_IDLE;
      idx_q      <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      rd_valid_q <= rd_valid_d;
    end
  end

  // Hold the query and tag the slot in flight
  always_ff @(posedge clk_i) begin
    if (start_i && (state_q == LK_IDLE)) begin
      query_q <= query_i;
    end
    rd_slot_q <= idx_q[IDX_W-1:0];
  end

endmodule

// File: rtl/core/indexed_text_record_parser_core.sv
// Top level of the indexed text record parser.
//
//  channel   direction  handshake                payload
//  command   in         start_i high, busy_o low func_i, data_byte_i, query_number_i
//  result    out        valid_o for one cycle    kind_o, status_o, record_number_o,
//                                                text_offset_o, text_length_o, slot_o
//
// A parse byte never raises busy_o, so bytes may follow every cycle while no lookup holds busy_o.
// A closed record's result appears on the cycle after the byte that closes it.
// A lookup holds busy_o until the query is found or every stored entry has been read;
// the entry table's single read port gives one entry a cycle.
// rst_ni clears the parser and the entry count; the table itself is not cleared.
// Results leave through an output register and cannot be held off by the receiver.
module indexed_text_record_parser_core #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned OFFSET_BITS = 20
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            func_i,
  input  logic [7:0]                      data_byte_i,
  input  logic [itrp_pkg::NUM_W-1:0]      query_number_i,
  output logic                            valid_o,
  output logic                            kind_o,
  output logic [1:0]                      status_o,
  output logic [itrp_pkg::NUM_W-1:0]      record_number_o,
  output logic [itrp_pkg::OFFSET_O_W-1:0] text_offset_o,
  output logic [itrp_pkg::LEN_W-1:0]      text_length_o,
  output logic [itrp_pkg::SLOT_W-1:0]     slot_o
);

  import itrp_pkg::*;

  localparam int unsigned IDX_W   = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned ENTRY_W = 2 * NUM_W + OFFSET_BITS;

  logic               accept;
  logic               byte_valid;
  logic               lookup_start;
  logic [CNT_W-1:0]   count;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  logic [ENTRY_W-1:0] rdata;
  logic               lk_busy;
  logic               prs_valid;
  logic               lk_valid;
  result_t            prs_res;
  result_t            lk_res;
  logic               valid_q;
  result_t            res_q;

  // Steer the accepted transaction
  assign accept       = start_i && !lk_busy;
  assign byte_valid   = accept && (func_i == FUNC_PARSE);
  assign lookup_start = accept && (func_i == FUNC_LOOKUP);

  itrp_parser #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .data_byte_i  (data_byte_i),
    .count_o      (count),
    .we_o         (we),
    .waddr_o      (waddr),
    .wdata_o      (wdata),
    .res_valid_o  (prs_valid),
    .res_o        (prs_res)
  );

  itrp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  itrp_lookup #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_lookup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (lookup_start),
    .query_i     (query_number_i),
    .count_i     (count),
    .re_o        (re),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .busy_o      (lk_busy),
    .res_valid_o (lk_valid),
    .res_o       (lk_res)
  );

  // Register the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= prs_valid || lk_valid;
    end
  end

  // Register the result payload; the two sources never finish together
  always_ff @(posedge clk_i) begin
    if (lk_valid) begin
      res_q <= lk_res;
    end else if (prs_valid) begin
      res_q <= prs_res;
    end
  end

  assign busy_o          = lk_busy;
  assign valid_o         = valid_q;
  assign kind_o          = res_q.kind;
  assign status_o        = res_q.status;
  assign record_number_o = res_q.number;
  assign text_offset_o   = res_q.offset;
  assign text_length_o   = res_q.length;
  assign slot_o          = res_q.slot;

endmodule

// File: rtl/core/itrp_checker.sv
// Port-level checker for the indexed text record parser, with its bind.
module itrp_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic func_i,
  input logic valid_o,
  input logic kind_o
);

  import itrp_pkg::*;

  // A lookup transaction always occupies the block for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == FUNC_LOOKUP)) |=> busy_o)
    else $error("lookup accepted without raising busy");

  // A parse transaction never makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && (func_i == FUNC_PARSE)) |=> !busy_o)
    else $error("parse byte raised busy");

  // A lookup answer shows just as busy drops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (kind_o == KIND_LOOKUP)) |-> $fell(busy_o))
    else $error("lookup answer without busy falling");

  // A parse result follows an accepted parse byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (kind_o == KIND_PARSE)) |->
      $past(start_i && !busy_o && (func_i == FUNC_PARSE)))
    else $error("parse result without a parse byte");

endmodule

bind indexed_text_record_parser_core itrp_checker u_itrp_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .func_i  (func_i),
  .valid_o (valid_o),
  .kind_o  (kind_o)
);

// File: dv/itrp_tb_pkg.sv
// Scoreboard and record table predictor for the indexed text record parser testbench.
package itrp_tb_pkg;
  import itrp_pkg::*;

  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned OFFSET_BITS = 20;

  class record_table_sb;
    parse_mode_e            mode;
    logic [NUM_W-1:0]       number_acc;
    logic [OFFSET_BITS-1:0] byte_pos;
    logic [OFFSET_BITS-1:0] text_start;
    logic [LEN_W-1:0]       text_len;
    int unsigned            n_entries;
    logic [NUM_W-1:0]       stored_number [TABLE_DEPTH];
    logic [OFFSET_BITS-1:0] stored_offset [TABLE_DEPTH];
    logic [LEN_W-1:0]       stored_length [TABLE_DEPTH];
    result_t                expected_q [$];
    int unsigned            errors;

    function new();
      mode       = PM_SCAN;
      number_acc = '0;
      byte_pos   = '0;
      text_start = '0;
      text_len   = '0;
      n_entries  = 0;
      errors     = 0;
    endfunction

    // Print one line per mismatch and count it
    task report_mismatch(string what);
      errors++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function void push_result(logic kind, logic [1:0] status, logic [NUM_W-1:0] num,
                              logic [OFFSET_BITS-1:0] off, logic [LEN_W-1:0] len,
                              logic [SLOT_W-1:0] slot);
      result_t r;
      r.kind   = kind;
      r.status = status;
      r.number = num;
      r.offset = off;
      r.length = len;
      r.slot   = slot;
      expected_q.push_back(r);
    endfunction

    // Advance the predicted parser or search the predicted table for one accepted transaction
    function void note_input(logic func, logic [7:0] b, logic [NUM_W-1:0] query);
      int unsigned acc;
      int          hit;
      if (func == FUNC_LOOKUP) begin
        hit = -1;
        for (int i = 0; i < n_entries && hit < 0; i++) begin
          if (stored_number[i] == query) hit = i;
        end
        if (hit < 0) begin
          push_result(KIND_LOOKUP, STATUS_NOT_FOUND, '0, '0, '0, '0);
        end else begin
          push_result(KIND_LOOKUP, STATUS_OK, query, stored_offset[hit],
                      stored_length[hit], SLOT_W'(hit));
        end
        return;
      end
      // once stopped, parse bytes change nothing
      if (mode == PM_STOP) return;
      case (mode)
        PM_SCAN: begin
          if (b == BYTE_STOP) begin
            mode = PM_STOP;
          end else if (b == BYTE_AT) begin
            number_acc = '0;
            mode       = PM_DIGITS;
          end
        end
        PM_DIGITS: begin
          if (b >= BYTE_ZERO && b < BYTE_ZERO + DEC_BASE) begin
            // saturate the record number
            acc        = 32'(number_acc) * DEC_BASE + 32'(b - BYTE_ZERO);
            number_acc = (acc > NUM_MAX) ? NUM_MAX : acc[NUM_W-1:0];
          end else if (b == BYTE_COLON) begin
            text_start = byte_pos + 1'b1;
            text_len   = '0;
            mode       = PM_TEXT;
          end else if (b == BYTE_STOP) begin
            mode = PM_STOP;
          end else begin
            mode = PM_SCAN;
          end
        end
        PM_TEXT: begin
          if (b >= BYTE_SPACE) begin
            if (text_len != LEN_MAX) text_len++;
          end else begin
            // close the record: store it, or drop it when the table is full
            if (n_entries < TABLE_DEPTH) begin
              stored_number[n_entries] = number_acc;
              stored_offset[n_entries] = text_start;
              stored_length[n_entries] = text_len;
              push_result(KIND_PARSE, STATUS_OK, number_acc, text_start, text_len,
                          SLOT_W'(n_entries));
              n_entries++;
            end else begin
              push_result(KIND_PARSE, STATUS_DROPPED, number_acc, text_start, text_len, '0);
            end
            mode = PM_SCAN;
          end
        end
        default: ;
      endcase
      byte_pos++;
    endfunction

    // Compare one result transaction with the oldest expectation, field by field
    task check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result: kind %0d status %0d number %0d slot %0d",
                                  got.kind, got.status, got.number, got.slot));
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind: got %0d, expected %0d", got.kind, want.kind));
      if (got.status !== want.status)
        report_mismatch($sformatf("status: got %0d, expected %0d", got.status, want.status));
      if (got.number !== want.number)
        report_mismatch($sformatf("record_number: got %0d, expected %0d",
                                  got.number, want.number));
      if (got.offset !== want.offset)
        report_mismatch($sformatf("text_offset: got %0d, expected %0d",
                                  got.offset, want.offset));
      if (got.length !== want.length)
        report_mismatch($sformatf("text_length: got %0d, expected %0d",
                                  got.length, want.length));
      if (got.slot !== want.slot)
        report_mismatch($sformatf("slot: got %0d, expected %0d", got.slot, want.slot));
    endtask
  endclass

endpackage

// File: dv/tb_top.sv
// Top level of the indexed text record parser testbench: clock, reset, stimulus and checks.
module tb_top;
  import itrp_pkg::*;
  import itrp_tb_pkg::*;

  localparam int unsigned LONG_TEXT    = 120;
  localparam int unsigned MIN_ITEMS    = 1600;
  localparam int unsigned TAIL_CYCLES  = TABLE_DEPTH + 80;

  logic                  clk_i          = 1'b0;
  logic                  rst_ni         = 1'b0;
  logic                  start_i        = 1'b0;
  logic                  func_i         = FUNC_PARSE;
  logic [7:0]            data_byte_i    = '0;
  logic [NUM_W-1:0]      query_number_i = '0;
  logic                  busy_o;
  logic                  valid_o;
  logic                  kind_o;
  logic [1:0]            status_o;
  logic [NUM_W-1:0]      record_number_o;
  logic [OFFSET_O_W-1:0] text_offset_o;
  logic [LEN_W-1:0]      text_length_o;
  logic [SLOT_W-1:0]     slot_o;

  record_table_sb sb;
  // parser mode once every byte sent so far has been taken; keeps stray stop codes out
  parse_mode_e    sent_mode = PM_SCAN;
  int unsigned    idle_pct  = 0;
  int unsigned    n_sent    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  indexed_text_record_parser_core #(
    .TABLE_DEPTH(TABLE_DEPTH),
    .OFFSET_BITS(OFFSET_BITS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .func_i         (func_i),
    .data_byte_i    (data_byte_i),
    .query_number_i (query_number_i),
    .valid_o        (valid_o),
    .kind_o         (kind_o),
    .status_o       (status_o),
    .record_number_o(record_number_o),
    .text_offset_o  (text_offset_o),
    .text_length_o  (text_length_o),
    .slot_o         (slot_o)
  );

  // Check the result strobe first, then note the transaction taken at this edge
  always @(posedge clk_i) begin : monitor
    result_t got;
    if (rst_ni) begin
      if (valid_o === 1'b1) begin
        got.kind   = kind_o;
        got.status = status_o;
        got.number = record_number_o;
        got.offset = text_offset_o;
        got.length = text_length_o;
        got.slot   = slot_o;
        sb.check_result(got);
      end
      if (start_i && !busy_o) sb.note_input(func_i, data_byte_i, query_number_i);
    end
  end

  // Present one transaction after a random gap and hold it until the block takes it
  task automatic issue(logic func, logic [7:0] b, logic [NUM_W-1:0] query);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    func_i         <= func;
    data_byte_i    <= b;
    query_number_i <= query;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    n_sent++;
  endtask

  // Send one resource byte; swap a stop code for a line feed unless it is wanted or ends the text
  task automatic send_byte(logic [7:0] b, bit stop_ok = 1'b0);
    logic [7:0] v;
    v = (b == BYTE_STOP && sent_mode != PM_TEXT && !stop_ok) ? 8'h0A : b;
    case (sent_mode)
      PM_SCAN: begin
        if (v == BYTE_STOP) sent_mode = PM_STOP;
        else if (v == BYTE_AT) sent_mode = PM_DIGITS;
      end
      PM_DIGITS: begin
        if (v == BYTE_COLON) sent_mode = PM_TEXT;
        else if (v == BYTE_STOP) sent_mode = PM_STOP;
        else if (v < BYTE_ZERO || v >= BYTE_ZERO + DEC_BASE) sent_mode = PM_SCAN;
      end
      PM_TEXT: begin
        if (v < BYTE_SPACE) sent_mode = PM_SCAN;
      end
      default: ;
    endcase
    issue(FUNC_PARSE, v, NUM_W'($urandom));
  endtask

  task automatic send_query(logic [NUM_W-1:0] q);
    issue(FUNC_LOOKUP, 8'($urandom), q);
  endtask

  // Send a well-formed record with random digits, printable text and a random terminator
  task automatic send_record(int unsigned n_digits, int unsigned n_text);
    send_byte(BYTE_AT);
    repeat (n_digits) send_byte(BYTE_ZERO + 8'($urandom_range(9)));
    send_byte(BYTE_COLON);
    repeat (n_text) send_byte(8'($urandom_range(255, 32)));
    send_byte(8'($urandom_range(31)));
  endtask

  initial begin : stimulus
    int unsigned first;
    int unsigned pick;
    int unsigned r;
    int unsigned n_dig;
    int unsigned n_txt;
    logic [7:0]  b;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty lookup, bare record, saturated number, abandon on '@',
    // stop code as a text terminator, then found and missing lookups
    send_query(16'd0);
    send_byte(BYTE_AT);
    send_byte(BYTE_COLON);
    send_byte(8'h00);
    send_byte(BYTE_AT);
    repeat (5) send_byte(BYTE_ZERO + 8'd9);
    send_byte(BYTE_COLON);
    send_byte(BYTE_SPACE);
    send_byte(8'hFF);
    send_byte(BYTE_SPACE - 8'd1);
    send_byte(BYTE_AT);
    send_byte(BYTE_ZERO + 8'd7);
    send_byte(BYTE_AT);
    send_byte(8'h7F);
    send_byte(BYTE_AT);
    send_byte(BYTE_ZERO + 8'd5);
    send_byte(BYTE_COLON);
    send_byte(BYTE_STOP);
    send_query(NUM_MAX);
    send_query(16'd5);
    send_query(16'h8001);

    // Hold one record open over a long run of printable text
    send_byte(BYTE_AT);
    send_byte(BYTE_ZERO + 8'd1);
    send_byte(BYTE_COLON);
    repeat (LONG_TEXT) send_byte(8'($urandom_range(255, 32)));
    send_byte(8'h0D);

    // Random: mostly short records, some noise, broken records and lookups
    first = n_sent;
    while (n_sent - first < MIN_ITEMS) begin
      case (((n_sent - first) / 400) % 4)
        1:       idle_pct = 69;
        3:       idle_pct = 32;
        default: idle_pct = 0;
      endcase
      pick = $urandom_range(99);
      if (pick < 4) begin
        if ($urandom_range(9) < 6) send_query(NUM_W'($urandom_range(99)));
        else send_query(NUM_W'($urandom));
      end else if (pick < 12) begin
        repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end else if (pick < 20) begin
        // broken record: a byte other than a digit or ':' after the number
        send_byte(BYTE_AT);
        repeat ($urandom_range(3)) send_byte(BYTE_ZERO + 8'($urandom_range(9)));
        do b = 8'($urandom);
        while (b == BYTE_COLON || b == BYTE_STOP || (b >= BYTE_ZERO && b < BYTE_ZERO + DEC_BASE));
        send_byte(b);
      end else begin
        r     = $urandom_range(19);
        n_dig = (r == 0) ? 0 : (r < 12) ? 1 : (r < 17) ? 2 : (r < 19) ? 4 : 6;
        r     = $urandom_range(19);
        n_txt = (r < 16) ? $urandom_range(1) : (r < 19) ? $urandom_range(8, 2)
                                                        : $urandom_range(40, 9);
        send_record(n_dig, n_txt);
      end
    end

    // Stop the parser between records or straight after the digits, then show that
    // later bytes are ignored while lookups still answer
    idle_pct = 32;
    if (sent_mode != PM_SCAN) send_byte(8'h0A);
    if ($urandom_range(1)) begin
      send_byte(BYTE_AT);
      send_byte(BYTE_ZERO + 8'($urandom_range(9)));
    end
    send_byte(BYTE_STOP, 1'b1);
    repeat (4) send_record(2, 1);
    repeat (12) send_byte(8'($urandom));
    repeat (3) send_query(NUM_W'($urandom_range(99)));
    repeat (3) send_query(NUM_W'($urandom));
    start_i <= 1'b0;

    // Drain outstanding results, then let the block settle
    for (int k = 0; k < 4 * TAIL_CYCLES && sb.expected_q.size() != 0; k++) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    while (sb.expected_q.size() != 0) begin
      void'(sb.expected_q.pop_front());
      sb.report_mismatch("expected result never arrived");
    end
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Give up long after the slowest correct run would have finished
  initial begin
    #40_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
